@@ design/rcf_pkg.sv @@
// Shared types and constants for the RGB 3x3 convolution filter.
`default_nettype none
package rcf_pkg;

  localparam int CHANNELS   = 3;
  localparam int PIX_W      = 8;
  localparam int RGB_W      = CHANNELS * PIX_W;
  localparam int TAPS       = 9;
  localparam int COEF_W     = 16;
  localparam int COEF_ROW_W = 3 * COEF_W;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int SUM_W      = PROD_W + 4;
  localparam int IMG_W_W    = 12;
  localparam int ROW_W      = 16;
  localparam int COL_OUT_W  = 11;
  localparam int CFG_IDX_W  = 3;

  localparam logic [IMG_W_W-1:0]    RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [ROW_W-1:0]      RST_IMAGE_HEIGHT = 16'd480;
  localparam logic [COEF_ROW_W-1:0] RST_COEF_ROW     = 48'h01C7_01C7_01C7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOT     = 3'd4
  } cfg_reg_t;

  // Position and status that travel alongside the arithmetic pipeline.
  typedef struct packed {
    logic                 valid;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } tag_t;

endpackage
`default_nettype wire

@@ design/rcf_line_mem.sv @@
// Line buffer memory: both previous rows of one column in a single entry.
`default_nettype none
module rcf_line_mem
  import rcf_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [2*RGB_W-1:0]   rd_data,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [2*RGB_W-1:0]   wr_data
);

  logic [2*RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/rcf_mac.sv @@
// One color channel: nine products, row sums, total, floor and clamp to 0..255.
`default_nettype none
module rcf_mac
  import rcf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         adv,
  input  wire logic [TAPS-1:0][PIX_W-1:0]   pix,
  input  wire logic [TAPS-1:0][COEF_W-1:0]  coef,
  output logic      [PIX_W-1:0]             result
);

  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [RSUM_W-1:0] rsum [3];
  logic signed [SUM_W-1:0]  total;
  logic        [SUM_W-1:0]  shifted;
  logic        [PIX_W-1:0]  result_next;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < TAPS; i++) begin
        prod[i] <= $signed({1'b0, pix[i]}) * $signed(coef[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        rsum[k] <= RSUM_W'(prod[3*k]) + RSUM_W'(prod[3*k+1]) + RSUM_W'(prod[3*k+2]);
      end
    end
  end

  always_comb begin
    total   = SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
    shifted = SUM_W'(total) >> COEF_FRAC_BITS;
    if (total < 0) begin
      result_next = '0;
    end else if (shifted > SUM_W'(255)) begin
      result_next = '1;
    end else begin
      result_next = shifted[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ design/rgb_conv3x3_filter.sv @@
// Top level of the RGB 3x3 convolution filter: counters, window and pipeline control.
//
// Pixels arrive in raster order on the input channel (in_valid / in_stall) with one
// 8-bit field per color. The block keeps the two previous rows in a line memory
// and a 3x3 window, and filters each color with the same signed fixed-point kernel.
// Only interior pixels give a result item on the output channel (out_valid /
// out_stall), tagged with the center position and a last-of-frame flag.
// Throughput is one pixel per clock while no result waits on out_stall. Each
// pixel costs one read and one write of its column's line memory entry. The
// fully pipelined path runs through stage 1, the window and the product, row-sum and
// result registers. Kernel and image size are written on the cfg port while idle.
// Reset restores 640x480, the box-blur kernel and empties the pipeline; the line
// memory is not cleared. When out_stall holds a waiting result, the whole pipeline
// freezes and in_stall is raised in the same cycle.
`default_nettype none
module rgb_conv3x3_filter
  import rcf_pkg::*;
#(
  parameter int MAX_WIDTH      = 2048,
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_ROW_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      in_red,
  input  wire logic [PIX_W-1:0]      in_green,
  input  wire logic [PIX_W-1:0]      in_blue,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [PIX_W-1:0]      out_red,
  output logic      [PIX_W-1:0]      out_green,
  output logic      [PIX_W-1:0]      out_blue,
  output logic      [COL_OUT_W-1:0]  center_col,
  output logic      [ROW_W-1:0]      center_row,
  output logic                       frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > IMG_W_W) ? WW : IMG_W_W;

  // Configuration registers.
  logic [IMG_W_W-1:0]    image_width;
  logic [ROW_W-1:0]      image_height;
  logic [COEF_ROW_W-1:0] coef_top;
  logic [COEF_ROW_W-1:0] coef_mid;
  logic [COEF_ROW_W-1:0] coef_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      coef_top     <= RST_COEF_ROW;
      coef_mid     <= RST_COEF_ROW;
      coef_bot     <= RST_COEF_ROW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        REG_COEF_TOP:     coef_top     <= cfg_data;
        REG_COEF_MID:     coef_mid     <= cfg_data;
        REG_COEF_BOT:     coef_bot     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes.
  logic [EW-1:0]    width_ext;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;

  always_comb begin
    width_ext = EW'(image_width);
    if (width_ext < EW'(3)) begin
      w_eff = WW'(3);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext[WW-1:0];
    end
    h_eff = (image_height < ROW_W'(3)) ? ROW_W'(3) : image_height;
  end

  // Pipeline control: everything moves unless a result waits on a stalled receiver.
  logic adv;
  logic in_acc;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // Position counters.
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [WW-1:0]    col_inc;
  logic [ROW_W:0]   row_inc;
  logic [CW-1:0]    col_count_next;
  logic [ROW_W-1:0] row_count_next;

  always_comb begin
    col_cur = (WW'(col_count) >= w_eff) ? '0 : col_count;
    row_cur = (row_count >= h_eff) ? '0 : row_count;
    col_inc = WW'(col_cur) + WW'(1);
    row_inc = (ROW_W + 1)'(row_cur) + (ROW_W + 1)'(1);
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= (ROW_W + 1)'(h_eff)) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_count_next = col_inc[CW-1:0];
      row_count_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Stage 1: pixel waits for its column's line memory entry.
  logic             s1_valid;
  logic [RGB_W-1:0] s1_px;
  logic [CW-1:0]    s1_col;
  tag_t             s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px      <= {in_blue, in_green, in_red};
      s1_col     <= col_cur;
      s1_tag.valid <= (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
      s1_tag.col <= COL_OUT_W'(col_cur - CW'(1));
      s1_tag.row <= row_cur - ROW_W'(1);
      s1_tag.last <= (row_cur == h_eff - ROW_W'(1)) && (WW'(col_cur) == w_eff - WW'(1));
    end
  end

  // Line memory: entry holds {row r-2, row r-1} of a column.
  logic               mem_wr_en;
  logic [2*RGB_W-1:0] mem_rd_data;
  logic [RGB_W-1:0]   line_top;
  logic [RGB_W-1:0]   line_mid;

  assign mem_wr_en = adv && s1_valid;
  assign line_top  = mem_rd_data[2*RGB_W-1:RGB_W];
  assign line_mid  = mem_rd_data[RGB_W-1:0];

  rcf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_cur),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_col),
    .wr_data ({line_mid, s1_px})
  );

  // Sliding window; index 0 is top-left, 8 is bottom-right.
  logic [TAPS-1:0][RGB_W-1:0] window;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (mem_wr_en) begin
      for (int k = 0; k < 3; k++) begin
        window[3*k]   <= window[3*k+1];
        window[3*k+1] <= window[3*k+2];
      end
      window[2] <= line_top;
      window[5] <= line_mid;
      window[8] <= s1_px;
    end
  end

  // Tag pipeline alongside the three arithmetic stages.
  tag_t t2;
  tag_t t3;
  tag_t t4;
  tag_t t_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2    <= '0;
      t3    <= '0;
      t4    <= '0;
      t_out <= '0;
    end else if (adv) begin
      t2.valid <= s1_valid && s1_tag.valid;
      t2.col   <= s1_tag.col;
      t2.row   <= s1_tag.row;
      t2.last  <= s1_tag.last;
      t3       <= t2;
      t4       <= t3;
      t_out    <= t4;
    end
  end

  // Kernel taps laid out in window order.
  logic [TAPS-1:0][COEF_W-1:0] coef_taps;
  logic [2:0][COEF_ROW_W-1:0]  coef_rows;

  always_comb begin
    coef_rows = {coef_bot, coef_mid, coef_top};
    for (int i = 0; i < TAPS; i++) begin
      coef_taps[i] = coef_rows[i/3][COEF_W*(i%3) +: COEF_W];
    end
  end

  logic [CHANNELS-1:0][PIX_W-1:0] chan_result;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    logic [TAPS-1:0][PIX_W-1:0] chan_pix;

    always_comb begin
      for (int i = 0; i < TAPS; i++) begin
        chan_pix[i] = window[i][PIX_W*ch +: PIX_W];
      end
    end

    rcf_mac #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
      .clk    (clk),
      .adv    (adv),
      .pix    (chan_pix),
      .coef   (coef_taps),
      .result (chan_result[ch])
    );
  end

  assign out_valid  = t_out.valid;
  assign out_red    = chan_result[0];
  assign out_green  = chan_result[1];
  assign out_blue   = chan_result[2];
  assign center_col = t_out.col;
  assign center_row = t_out.row;
  assign frame_last = t_out.last;

  // A column's entry is never read and written back in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_acc && mem_wr_en |-> col_cur != s1_col)
    else $error("line memory read and write collide on one column");

  // Results come only from interior centers.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (center_col != '0) && (center_row != '0))
    else $error("result for a border pixel");

  // A new result only follows an interior item leaving the last arithmetic stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(t4.valid) && $past(adv))
    else $error("result without a matching item in the pipeline");

  // The memory writes back only the item that occupied the read stage.
  assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> $past(in_acc) || $past(s1_valid))
    else $error("line memory write without a pending item");

endmodule
`default_nettype wire
